/* hw/rtl/signed_int128_alu_core_macros.svh */
// Assertion helpers for the checker file of the ALU core.
`ifndef SIGNED_INT128_ALU_CORE_MACROS_SVH
`define SIGNED_INT128_ALU_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SIALU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ALU core check failed in %m");

// Next-cycle implication, checked on every rising edge outside reset.
`define SIALU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ALU core check failed in %m");

`endif

/* hw/rtl/sialu_pkg.sv */
package sialu_pkg;

  // Default operand width in bits.
  localparam int ALU_WIDTH = 128;

  // Action codes of a request.
  localparam logic [3:0] ACT_ADD = 4'd0;
  localparam logic [3:0] ACT_SUB = 4'd1;
  localparam logic [3:0] ACT_MUL = 4'd2;
  localparam logic [3:0] ACT_DIV = 4'd3;
  localparam logic [3:0] ACT_AND = 4'd4;
  localparam logic [3:0] ACT_OR  = 4'd5;
  localparam logic [3:0] ACT_XOR = 4'd6;
  localparam logic [3:0] ACT_NOT = 4'd7;
  localparam logic [3:0] ACT_SHL = 4'd8;
  localparam logic [3:0] ACT_SAR = 4'd9;
  localparam logic [3:0] ACT_ROL = 4'd10;
  localparam logic [3:0] ACT_ROR = 4'd11;

  typedef struct packed {
    logic [3:0]  action;
    logic [63:0] a_hi;
    logic [63:0] a_lo;
    logic [63:0] b_hi;
    logic [63:0] b_lo;
    logic [7:0]  shift_amount;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    logic        divide_by_zero;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
    logic fix;
    logic wb;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_mul;
    logic is_div;
  } dp_sts_t;

endpackage

/* hw/rtl/sialu_dp.sv */
module sialu_dp import sialu_pkg::*; #(
  parameter int WIDTH = ALU_WIDTH
) (
  input  logic      clk,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_item_t out_data
);

  localparam int HI_W = WIDTH - 64;
  localparam logic [7:0] SHL_LIMIT = 8'(WIDTH);
  localparam logic [7:0] SAR_MAX   = 8'(WIDTH - 1);

  logic [WIDTH-1:0] op_a;
  logic [WIDTH-1:0] op_b;
  logic [WIDTH-1:0] abs_a;
  logic [WIDTH-1:0] abs_b;
  logic             b_zero;
  logic [7:0]       sar_amt;
  logic [WIDTH-1:0] quick_res;
  logic             quick_dz;

  logic [WIDTH-1:0] x_r;
  logic [WIDTH-1:0] y_r;
  logic [WIDTH-1:0] z_r;
  logic             neg_r;
  logic             dz_r;
  out_item_t        out_data_r;

  logic [WIDTH-1:0] mul_sum;
  logic [WIDTH:0]   div_shift;
  logic [WIDTH:0]   div_diff;
  logic             div_take;

  assign op_a   = {in_data.a_hi[HI_W-1:0], in_data.a_lo};
  assign op_b   = {in_data.b_hi[HI_W-1:0], in_data.b_lo};
  assign abs_a  = op_a[WIDTH-1] ? ('0 - op_a) : op_a;
  assign abs_b  = op_b[WIDTH-1] ? ('0 - op_b) : op_b;
  assign b_zero = (op_b == '0);

  assign sts.is_mul = (in_data.action == ACT_MUL);
  assign sts.is_div = (in_data.action == ACT_DIV) && !b_zero;

  assign sar_amt = (in_data.shift_amount > SAR_MAX) ? SAR_MAX : in_data.shift_amount;

  // Results of add, sub, logic, shift and rotate actions; multiply and divide start from zero here.
  always_comb begin
    quick_res = '0;
    quick_dz  = 1'b0;
    unique case (in_data.action) inside
      ACT_ADD: quick_res = op_a + op_b;
      ACT_SUB: quick_res = op_a - op_b;
      ACT_AND: quick_res = op_a & op_b;
      ACT_OR:  quick_res = op_a | op_b;
      ACT_XOR: quick_res = op_a ^ op_b;
      ACT_NOT: quick_res = ~op_a;
      ACT_SHL: begin
        if (in_data.shift_amount < SHL_LIMIT) begin
          quick_res = op_a << in_data.shift_amount;
        end
      end
      ACT_SAR: quick_res = WIDTH'($signed(op_a) >>> sar_amt);
      ACT_ROL: quick_res = {op_a[WIDTH-2:0], op_a[WIDTH-1]};
      ACT_ROR: quick_res = {op_a[0], op_a[WIDTH-1:1]};
      ACT_MUL, ACT_DIV: begin
        quick_res = '0;
        quick_dz  = (in_data.action == ACT_DIV) && b_zero;
      end
      default: quick_res = '0;
    endcase
  end

  // One shift-add multiply step and one restoring divide step.
  assign mul_sum   = z_r + (y_r[0] ? x_r : '0);
  assign div_shift = {z_r, x_r[WIDTH-1]};
  assign div_diff  = div_shift - {1'b0, y_r};
  assign div_take  = !div_diff[WIDTH];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dz_r  <= quick_dz;
      neg_r <= op_a[WIDTH-1] ^ op_b[WIDTH-1];
      x_r   <= sts.is_div ? abs_a : op_a;
      y_r   <= sts.is_div ? abs_b : op_b;
      z_r   <= quick_res;
    end else if (cmd.mul_step) begin
      z_r <= mul_sum;
      x_r <= x_r << 1;
      y_r <= y_r >> 1;
    end else if (cmd.div_step) begin
      z_r <= div_take ? div_diff[WIDTH-1:0] : div_shift[WIDTH-1:0];
      x_r <= {x_r[WIDTH-2:0], div_take};
    end else if (cmd.fix) begin
      z_r <= neg_r ? ('0 - x_r) : x_r;
    end
    if (cmd.wb) begin
      out_data_r.result_hi      <= 64'(z_r[WIDTH-1:64]);
      out_data_r.result_lo      <= z_r[63:0];
      out_data_r.divide_by_zero <= dz_r;
    end
  end

  assign out_data = out_data_r;

endmodule

/* hw/rtl/sialu_ctrl.sv */
module sialu_ctrl import sialu_pkg::*; #(
  parameter int WIDTH = ALU_WIDTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             accept;
  logic             out_free;

  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          cmd.load = 1'b1;
          if (sts.is_mul) begin
            state_nxt = S_MUL;
          end else if (sts.is_div) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_WB;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_WB;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          cmd.wb        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/signed_int128_alu_core.sv */
// Add, sub, logic, shift and rotate results, and a division by zero, go from the working
// registers to the output register; multiply runs a shift-add loop (one partial product per cycle)
// and divide a restoring loop (one restoring step per cycle) followed by a sign fix-up state.
// Write-back waits for a free output register; only then can a new request be accepted.
// Reset (rst_n low, synchronous) returns the controller to idle and drops out_valid;
// in_stall is held high while reset is asserted.
module signed_int128_alu_core import sialu_pkg::*; #(
  parameter int WIDTH = ALU_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // The controller accepts a request only while idle. At acceptance the
  // datapath either finishes the action outright (add, sub, logic, shifts,
  // rotates, and division by zero) or loads the working registers for the
  // iterative multiply or divide. The shared x, y and z registers hold the
  // multiplicand, multiplier and product for a multiply, and the quotient
  // shift register, divisor magnitude and partial remainder for a divide.
  //
  // A finished result moves into the output register once that register is
  // free or being taken in the same cycle. The controller is idle again
  // right after that transfer, so the next request can be accepted while
  // the previous result is still held against out_stall.

  dp_cmd_t cmd;
  dp_sts_t sts;

  // State machine: step counter, handshake and sequencing of the datapath.
  sialu_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Operand decode, the add, sub, logic, shift and rotate functions, the multiply and divide step
  // logic, and the output register.
  sialu_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* hw/rtl/sialu_checker.sv */
`include "signed_int128_alu_core_macros.svh"

module sialu_checker import sialu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A held result stays offered.
  `SIALU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // A held result does not change.
  `SIALU_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))

  // A division by zero always reports a zero quotient.
  `SIALU_ASSERT_NOW(a_dz_zero, out_valid && out_data.divide_by_zero, (out_data.result_hi == 64'd0) && (out_data.result_lo == 64'd0))

  // The core works on one request at a time, so it is busy right after taking one.
  `SIALU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind signed_int128_alu_core sialu_checker u_chk (.*);
